// ----- sv/pidc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types and constants for the pid controller with integrator clamp
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 32;
  localparam int DRIVE_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int MODE_W     = 3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_P         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PI        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PI_CLAMP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PID       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PID_CLAMP = 3'd4;

  // register indices
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_MAX = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_MIN = 3'd6;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7fff_ffff;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } pidc_gains_t;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] hi;
    logic signed [LIMIT_W-1:0] lo;
  } pidc_limits_t;

endpackage

// ----- sv/pidc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module pidc_cfg
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  output logic signed [MEAS_WIDTH-1:0] target,
  output logic [MODE_W-1:0]            mode,
  output pidc_gains_t                  gains,
  output pidc_limits_t                 limits
);

  logic signed [MEAS_WIDTH-1:0] target_r;
  logic [MODE_W-1:0]            mode_r;
  pidc_gains_t                  gains_r;
  pidc_limits_t                 limits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      mode_r    <= MODE_PID;
      gains_r   <= '0;
      limits_r.hi <= DRIVE_MAX;
      limits_r.lo <= DRIVE_MIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET:    target_r    <= cfg_wdata[MEAS_WIDTH-1:0];
        REG_MODE:      mode_r      <= cfg_wdata[MODE_W-1:0];
        REG_GAIN_P:    gains_r.p   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    gains_r.i   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    gains_r.d   <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_MAX: limits_r.hi <= cfg_wdata[LIMIT_W-1:0];
        REG_INTEG_MIN: limits_r.lo <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign target = target_r;
  assign mode   = mode_r;
  assign gains  = gains_r;
  assign limits = limits_r;

endmodule

// ----- sv/pidc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_front
// input register, error, measurement difference and integrator update
// ----------------------------------------------------------------------------
module pidc_front
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH  = 16,
  parameter int INTEG_WIDTH = 32,
  localparam int ERR_W = MEAS_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [MEAS_WIDTH-1:0]  target,
  input  logic [MODE_W-1:0]             mode,
  input  pidc_limits_t                  limits,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [MEAS_WIDTH-1:0]  in_measurement,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [ERR_W-1:0]       dn_err,
  output logic signed [ERR_W-1:0]       dn_diff,
  output logic signed [INTEG_WIDTH-1:0] dn_integ
);

  localparam int WIDE0 = (INTEG_WIDTH > MEAS_WIDTH) ? INTEG_WIDTH : MEAS_WIDTH;
  localparam int WIDE1 = (WIDE0 > LIMIT_W) ? WIDE0 : LIMIT_W;
  localparam int ACC_W = WIDE1 + 2;

  logic                          v0_r, v0_nxt;
  logic signed [MEAS_WIDTH-1:0]  meas_r;
  logic                          v1_r, v1_nxt;
  logic signed [ERR_W-1:0]       err_r, diff_r;
  logic signed [INTEG_WIDTH-1:0] integ_out_r;
  logic signed [INTEG_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [MEAS_WIDTH-1:0]  last_r;
  logic                          adv;
  logic                          en_p, en_i, en_d, en_clamp;
  logic signed [ERR_W-1:0]       err, diff;
  logic signed [ACC_W-1:0]       acc, acc_lim;
  logic                          acc_fits;

  assign adv      = !v1_r || dn_ready;
  assign in_ready = !v0_r || adv;
  assign v0_nxt   = in_ready ? in_valid : v0_r;
  assign v1_nxt   = adv ? v0_r : v1_r;

  assign en_p     = (mode <= MODE_PID_CLAMP);
  assign en_i     = en_p && (mode != MODE_P);
  assign en_d     = (mode == MODE_PID) || (mode == MODE_PID_CLAMP);
  assign en_clamp = (mode == MODE_PI_CLAMP) || (mode == MODE_PID_CLAMP);

  assign err  = ERR_W'(target) - ERR_W'(meas_r);
  assign diff = ERR_W'(last_r) - ERR_W'(meas_r);

  always_comb begin
    acc = ACC_W'(integ_r) + ACC_W'(err);
    acc_lim = acc;
    if (en_clamp) begin
      if (acc > ACC_W'(limits.hi)) begin
        acc_lim = ACC_W'(limits.hi);
      end else if (acc < ACC_W'(limits.lo)) begin
        acc_lim = ACC_W'(limits.lo);
      end
    end
    acc_fits = (&acc_lim[ACC_W-1:INTEG_WIDTH-1]) || !(|acc_lim[ACC_W-1:INTEG_WIDTH-1]);
    if (!en_i) begin
      integ_nxt = integ_r;
    end else if (acc_fits) begin
      integ_nxt = acc_lim[INTEG_WIDTH-1:0];
    end else if (acc_lim[ACC_W-1]) begin
      integ_nxt = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
    end else begin
      integ_nxt = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      if (adv && v0_r) begin
        integ_r <= integ_nxt;
        last_r  <= meas_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      meas_r <= in_measurement;
    end
    if (adv && v0_r) begin
      err_r       <= en_p ? err : '0;
      diff_r      <= en_d ? diff : '0;
      integ_out_r <= en_i ? integ_nxt : '0;
    end
  end

  assign dn_valid = v1_r;
  assign dn_err   = err_r;
  assign dn_diff  = diff_r;
  assign dn_integ = integ_out_r;

endmodule

// ----- sv/pidc_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mult
// gain products, one registered stage
// ----------------------------------------------------------------------------
module pidc_mult
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH  = 16,
  parameter int INTEG_WIDTH = 32,
  localparam int ERR_W = MEAS_WIDTH + 1,
  localparam int PD_W  = GAIN_W + ERR_W,
  localparam int PI_W  = GAIN_W + INTEG_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pidc_gains_t                   gains,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [ERR_W-1:0]       up_err,
  input  logic signed [ERR_W-1:0]       up_diff,
  input  logic signed [INTEG_WIDTH-1:0] up_integ,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [PD_W-1:0]        dn_p,
  output logic signed [PI_W-1:0]        dn_i,
  output logic signed [PD_W-1:0]        dn_d
);

  logic                   v_r, v_nxt;
  logic signed [PD_W-1:0] p_r, p_nxt, d_r, d_nxt;
  logic signed [PI_W-1:0] i_r, i_nxt;

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;

  assign p_nxt = PD_W'($signed(gains.p)) * PD_W'(up_err);
  assign d_nxt = PD_W'($signed(gains.d)) * PD_W'(up_diff);
  assign i_nxt = PI_W'($signed(gains.i)) * PI_W'(up_integ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p_r <= p_nxt;
      i_r <= i_nxt;
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_p     = p_r;
  assign dn_i     = i_r;
  assign dn_d     = d_r;

endmodule

// ----- sv/pidc_sat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_sat
// term sum, fractional shift, output saturation and result register
// ----------------------------------------------------------------------------
module pidc_sat
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH     = 16,
  parameter int INTEG_WIDTH    = 32,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int PD_W = GAIN_W + MEAS_WIDTH + 1,
  localparam int PI_W = GAIN_W + INTEG_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [PD_W-1:0] up_p,
  input  logic signed [PI_W-1:0] up_i,
  input  logic signed [PD_W-1:0] up_d,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DRIVE_W-1:0]     out_drive,
  output logic                   out_clipped
);

  localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

  logic                     v_r, v_nxt;
  logic [DRIVE_W-1:0]       drive_r, drive_nxt;
  logic                     clip_r, clip_nxt;
  logic signed [SUM_W-1:0]  sum, shifted;
  logic                     fits;

  assign up_ready = !v_r || out_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;

  assign sum     = SUM_W'(up_p) + SUM_W'(up_i) + SUM_W'(up_d);
  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign fits    = (&shifted[SUM_W-1:DRIVE_W-1]) || !(|shifted[SUM_W-1:DRIVE_W-1]);

  always_comb begin
    clip_nxt = !fits;
    if (fits) begin
      drive_nxt = shifted[DRIVE_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      drive_nxt = DRIVE_MIN;
    end else begin
      drive_nxt = DRIVE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      drive_r <= drive_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid   = v_r;
  assign out_drive   = drive_r;
  assign out_clipped = clip_r;

endmodule

// ----- sv/pid_controller_with_integrator_clamp_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_integrator_clamp_unit
// fixed point pid controller with optional integrator clamp
//
//   channel   direction   signals
//   in        slave       in_valid, in_ready, in_measurement
//   out       master      out_valid, out_ready, out_drive, out_clipped
//   cfg       write only  cfg_we, cfg_addr, cfg_wdata
//
// one beat per cycle sustained while out_ready stays high, the result
// passing through four registers (input register, integrator stage,
// product stage, result register) once the input beat is accepted
// the integrator and last measurement update as a beat leaves the input
// register, so back to back beats see each other's state
// synchronous reset clears integrator, last measurement and all valid bits
// each stage holds on a stall and accepts again once its successor frees
// ----------------------------------------------------------------------------
module pid_controller_with_integrator_clamp_unit
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH     = 16,
  parameter int INTEG_WIDTH    = 32,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [MEAS_WIDTH-1:0] in_measurement,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DRIVE_W-1:0]           out_drive,
  output logic                         out_clipped
);

  localparam int ERR_W = MEAS_WIDTH + 1;
  localparam int PD_W  = GAIN_W + ERR_W;
  localparam int PI_W  = GAIN_W + INTEG_WIDTH;

  logic signed [MEAS_WIDTH-1:0]  target;
  logic [MODE_W-1:0]             mode;
  pidc_gains_t                   gains;
  pidc_limits_t                  limits;

  logic                          f_valid, f_ready;
  logic signed [ERR_W-1:0]       f_err, f_diff;
  logic signed [INTEG_WIDTH-1:0] f_integ;

  logic                          m_valid, m_ready;
  logic signed [PD_W-1:0]        m_p, m_d;
  logic signed [PI_W-1:0]        m_i;

  pidc_cfg #(
    .MEAS_WIDTH (MEAS_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .target    (target),
    .mode      (mode),
    .gains     (gains),
    .limits    (limits)
  );

  pidc_front #(
    .MEAS_WIDTH  (MEAS_WIDTH),
    .INTEG_WIDTH (INTEG_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .target         (target),
    .mode           (mode),
    .limits         (limits),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_measurement (in_measurement),
    .dn_valid       (f_valid),
    .dn_ready       (f_ready),
    .dn_err         (f_err),
    .dn_diff        (f_diff),
    .dn_integ       (f_integ)
  );

  pidc_mult #(
    .MEAS_WIDTH  (MEAS_WIDTH),
    .INTEG_WIDTH (INTEG_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .gains    (gains),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_err   (f_err),
    .up_diff  (f_diff),
    .up_integ (f_integ),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .dn_p     (m_p),
    .dn_i     (m_i),
    .dn_d     (m_d)
  );

  pidc_sat #(
    .MEAS_WIDTH     (MEAS_WIDTH),
    .INTEG_WIDTH    (INTEG_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (m_valid),
    .up_ready    (m_ready),
    .up_p        (m_p),
    .up_i        (m_i),
    .up_d        (m_d),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .out_clipped (out_clipped)
  );

  // a clipped drive sits on one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_drive == DRIVE_MAX) || (out_drive == DRIVE_MIN))
    else $error("clipped drive off the rails");

  // all gains zero gives a zero drive
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (gains == '0) |-> (out_drive == '0) && !out_clipped)
    else $error("nonzero drive with zero gains");

  // pipeline empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !f_valid && !m_valid)
    else $error("beat present after reset");

  // a stalled result stage holds back the product stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && m_valid |-> !m_ready)
    else $error("product stage advanced into a full result stage");

endmodule
